// ===== rtl/stle_pkg.sv =====
`timescale 1ns / 1ps
package stle_pkg;
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DISPLAY = 2'd1,
		OP_DONE    = 2'd2,
		OP_DELETE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_FULL         = 3'd1,
		ST_NOT_FOUND    = 3'd2,
		ST_ALREADY_DONE = 3'd3,
		ST_EMPTY        = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [23:0] due_key;
		logic [7:0]  priority_req;
		logic [15:0] tag;
		logic [3:0]  index;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  position;
		logic [23:0] due_key_res;
		logic [7:0]  priority_out;
		logic [15:0] tag_out;
		logic        done_res;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [23:0] due;
		logic [7:0]  pri;
		logic [15:0] tag;
		logic        done;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISP,
		S_RESP
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic       do_insert;
		logic       do_done;
		logic       do_delete;
		logic       load_ptr;
		logic       step_ptr;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             idx_ok;
		logic             sel_done;
		logic             ptr_last;
	} stat_t;
endpackage

// ===== rtl/stle_if.sv =====
`timescale 1ns / 1ps
interface stle_in_if;
	logic valid;
	logic ready;
	stle_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stle_out_if.sv =====
`timescale 1ns / 1ps
interface stle_out_if;
	logic valid;
	logic ready;
	stle_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sorted_task_list_engine_unit.sv =====
`timescale 1ns / 1ps
// A word is answered in the cycle after it is accepted.
// Insert, mark done and delete accept no new word until the response is taken;
// display shows one entry per cycle while out_ready is high, and no new word
// is accepted until the last entry has been taken.
// Reset: arst_n asynchronously empties the table and returns the controller
// to idle; table contents are left as they were.
module sorted_task_list_engine_unit (
	input logic clk,
	input logic arst_n,
	stle_in_if.sink    in_ch,
	stle_out_if.source out_ch
);
	import stle_pkg::*;

	cmd_t   cmd;
	stat_t  stat;
	entry_t rd_entry;
	logic [IDX_W-1:0] ptr;

	// The controller sequences each command and the display stream.
	stle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.op        (in_ch.data.operation),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_data  (out_ch.data),
		.cmd       (cmd),
		.stat      (stat),
		.rd_entry  (rd_entry),
		.ptr       (ptr)
	);

	// The datapath holds the ordered cell chain and the entry count.
	stle_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (in_ch.data),
		.stat     (stat),
		.rd_entry (rd_entry),
		.ptr      (ptr)
	);
endmodule

// ===== rtl/stle_datapath.sv =====
`timescale 1ns / 1ps
module stle_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  stle_pkg::cmd_t      cmd,
	input  stle_pkg::in_word_t  req,
	output stle_pkg::stat_t     stat,
	output stle_pkg::entry_t    rd_entry,
	output logic [stle_pkg::IDX_W-1:0] ptr
);
	import stle_pkg::*;

	// Each cell shifts from its neighbor or loads new data, so the table
	// updates at once, with no sequential search.
	entry_t           cell_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] ptr_q;
	logic [DEPTH-1:0] after;
	logic [CNT_W-1:0] slot;
	entry_t           sel;

	// Done entries sit at the tail out of key order, so the new entry goes
	// before the first valid cell that it does not sort after.
	always_comb begin
		slot = count_q;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			after[i] = (CNT_W'(i) < count_q) &&
				((req.due_key != cell_q[i].due) ? (req.due_key > cell_q[i].due)
				: (req.priority_req > cell_q[i].pri));
			if (CNT_W'(i) < count_q && !after[i])
				slot = CNT_W'(i);
		end
	end

	assign sel = cell_q[req.index[IDX_W-1:0]];

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.do_insert) begin
				if (CNT_W'(i) == slot)
					cell_q[i] <= '{req.due_key, req.priority_req, req.tag, 1'b0};
				else if (CNT_W'(i) > slot && i > 0)
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
			end else if (cmd.do_done || cmd.do_delete) begin
				if (i >= int'(req.index[IDX_W-1:0])) begin
					if (CNT_W'(i + 1) == count_q) begin
						if (cmd.do_done)
							cell_q[i] <= '{sel.due, sel.pri, sel.tag, 1'b1};
					end else if (i < DEPTH - 1)
						cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.do_insert)
				count_q <= count_q + 1'b1;
			else if (cmd.do_delete)
				count_q <= count_q - 1'b1;
			if (cmd.load_ptr)
				ptr_q <= '0;
			else if (cmd.step_ptr)
				ptr_q <= ptr_q + 1'b1;
		end
	end

	// The controller refuses an insert when the table is full, so a full table never inserts here.
	assign stat.count    = count_q;
	assign stat.idx_ok   = CNT_W'(req.index) < count_q;
	assign stat.sel_done = sel.done;
	assign stat.ptr_last = (CNT_W'(ptr_q) + 1'b1) == count_q;
	assign rd_entry      = cell_q[ptr_q];
	assign ptr           = ptr_q;
endmodule

// ===== rtl/stle_ctrl.sv =====
`timescale 1ns / 1ps
module stle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         op,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	output stle_pkg::out_word_t out_data,
	output stle_pkg::cmd_t     cmd,
	input  stle_pkg::stat_t    stat,
	input  stle_pkg::entry_t   rd_entry,
	input  logic [stle_pkg::IDX_W-1:0] ptr
);
	import stle_pkg::*;

	state_t    state_q, state_d;
	out_word_t resp_q, resp_d;
	logic      accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (op == OP_DISPLAY && stat.count != '0) ? S_DISP : S_RESP;
			end
			S_DISP: begin
				if (out_ready && stat.ptr_last)
					state_d = S_IDLE;
			end
			S_RESP: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd    = '0;
		resp_d = '0;
		resp_d.last = 1'b1;
		if (accept) begin
			cmd.load_ptr = 1'b1;
			case (op)
				OP_INSERT: begin
					if (stat.count == CNT_W'(DEPTH))
						resp_d.status = ST_FULL;
					else
						cmd.do_insert = 1'b1;
				end
				OP_DISPLAY: resp_d.status = ST_EMPTY;
				OP_DONE: begin
					if (!stat.idx_ok)
						resp_d.status = ST_NOT_FOUND;
					else if (stat.sel_done)
						resp_d.status = ST_ALREADY_DONE;
					else
						cmd.do_done = 1'b1;
				end
				OP_DELETE: begin
					if (!stat.idx_ok)
						resp_d.status = ST_NOT_FOUND;
					else
						cmd.do_delete = 1'b1;
				end
				default: resp_d.status = ST_OK;
			endcase
		end
		if (state_q == S_DISP && out_ready)
			cmd.step_ptr = 1'b1;
	end

	always_comb begin
		if (state_q == S_DISP) begin
			out_data = '{ST_OK, 4'(ptr), rd_entry.due, rd_entry.pri, rd_entry.tag,
				rd_entry.done, stat.ptr_last};
		end else
			out_data = resp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept)
			resp_q <= resp_d;
	end
endmodule
